// ===== rtl/core/mtrd_pkg.sv =====
package mtrd_pkg;

    localparam int POS_W       = 17;
    localparam int WORD_IDX_W  = 7;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    // Byte positions within a frame.
    localparam logic [POS_W-1:0] POS_TID_HI   = POS_W'(0);
    localparam logic [POS_W-1:0] POS_TID_LO   = POS_W'(1);
    localparam logic [POS_W-1:0] POS_LEN_HI   = POS_W'(4);
    localparam logic [POS_W-1:0] POS_LEN_LO   = POS_W'(5);
    localparam logic [POS_W-1:0] POS_UNIT     = POS_W'(6);
    localparam logic [POS_W-1:0] POS_FUNC     = POS_W'(7);
    localparam logic [POS_W-1:0] POS_BYTE8    = POS_W'(8);
    localparam logic [POS_W-1:0] POS_DATA     = POS_W'(9);

    localparam logic [POS_W-1:0] HDR_BYTES      = POS_W'(6);
    localparam logic [POS_W-1:0] MIN_FRAME      = POS_W'(8);
    localparam logic [POS_W-1:0] EXC_CODE_FRAME = POS_W'(9);
    localparam int               FUNC_EXC_BIT   = 7;

    localparam logic KIND_WORD    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXCEPTION = 2'd1,
        ST_TOO_SHORT = 2'd2
    } t_status;

    typedef struct packed {
        logic                  kind;
        logic [15:0]           trans_id;
        logic [7:0]            unit_id;
        logic [7:0]            func_code;
        t_status               frame_status;
        logic [7:0]            exc_code;
        logic [15:0]           frame_length;
        logic [15:0]           register_value;
        logic [WORD_IDX_W-1:0] word_index;
        logic                  last;
    } t_result;

    // Results caused by one accepted byte, packed from the first slot.
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_emit;

endpackage

// ===== rtl/core/mtrd_parser.sv =====
module mtrd_parser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_data_byte,
    output mtrd_pkg::t_emit o_emit
);
    import mtrd_pkg::*;

    logic [POS_W-1:0]      r_pos, n_pos;
    logic [15:0]           r_trans, n_trans;
    logic [15:0]           r_len, n_len;
    logic [7:0]            r_unit, n_unit;
    logic [7:0]            r_func, n_func;
    logic [7:0]            r_byte8, n_byte8;
    logic [7:0]            r_high, n_high;
    logic [WORD_IDX_W-1:0] r_wc, n_wc;

    logic [POS_W-1:0] total;
    logic             frame_end;
    logic             word_valid;
    t_result          word_res;
    t_result          sum_res;

    always_comb begin
        n_trans = r_trans;
        n_len   = r_len;
        n_unit  = r_unit;
        n_func  = r_func;
        n_byte8 = r_byte8;
        n_high  = r_high;
        n_wc    = r_wc;
        case (r_pos)
            POS_TID_HI: n_trans = {i_data_byte, 8'h00};
            POS_TID_LO: n_trans = {r_trans[15:8], i_data_byte};
            POS_LEN_HI: n_len   = {i_data_byte, 8'h00};
            POS_LEN_LO: n_len   = {r_len[15:8], i_data_byte};
            POS_UNIT:   n_unit  = i_data_byte;
            POS_FUNC:   n_func  = i_data_byte;
            POS_BYTE8:  n_byte8 = i_data_byte;
            default: ;
        endcase

        total     = HDR_BYTES + POS_W'(n_len);
        n_pos     = r_pos + POS_W'(1);
        frame_end = (r_pos >= POS_LEN_LO) && (n_pos >= total);

        // Data bytes pair up as odd/even positions; the even byte completes a word.
        word_valid = 1'b0;
        if ((r_pos >= POS_DATA) && !r_func[FUNC_EXC_BIT]) begin
            if (r_pos[0]) begin
                n_high = i_data_byte;
            end else begin
                word_valid = ({r_wc, 1'b0} < r_byte8);
                n_wc       = r_wc + WORD_IDX_W'(1);
            end
        end

        word_res.kind           = KIND_WORD;
        word_res.trans_id       = n_trans;
        word_res.unit_id        = n_unit;
        word_res.func_code      = n_func;
        word_res.frame_status   = ST_OK;
        word_res.exc_code       = 8'h00;
        word_res.frame_length   = n_len;
        word_res.register_value = {r_high, i_data_byte};
        word_res.word_index     = r_wc;
        word_res.last           = 1'b0;

        sum_res                 = word_res;
        sum_res.kind            = KIND_SUMMARY;
        sum_res.register_value  = 16'h0000;
        sum_res.word_index      = '0;
        sum_res.last            = 1'b1;
        if (total < MIN_FRAME) begin
            sum_res.frame_status = ST_TOO_SHORT;
            sum_res.func_code    = 8'h00;
        end else if (n_func[FUNC_EXC_BIT]) begin
            sum_res.frame_status = ST_EXCEPTION;
            sum_res.exc_code     = (total >= EXC_CODE_FRAME) ? n_byte8 : 8'h00;
        end else begin
            sum_res.frame_status = ST_OK;
        end

        o_emit.second = sum_res;
        if (word_valid) begin
            o_emit.first = word_res;
            o_emit.count = frame_end ? 2'd2 : 2'd1;
        end else begin
            o_emit.first = sum_res;
            o_emit.count = frame_end ? 2'd1 : 2'd0;
        end
        if (!i_accept) begin
            o_emit.count = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && frame_end)) begin
            r_pos   <= '0;
            r_trans <= '0;
            r_len   <= '0;
            r_unit  <= '0;
            r_func  <= '0;
            r_byte8 <= '0;
            r_high  <= '0;
            r_wc    <= '0;
        end else if (i_accept) begin
            r_pos   <= n_pos;
            r_trans <= n_trans;
            r_len   <= n_len;
            r_unit  <= n_unit;
            r_func  <= n_func;
            r_byte8 <= n_byte8;
            r_high  <= n_high;
            r_wc    <= n_wc;
        end
    end

endmodule

// ===== rtl/core/mtrd_result_fifo.sv =====
module mtrd_result_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mtrd_pkg::t_emit   i_emit,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_ready,
    output mtrd_pkg::t_result o_result
);
    import mtrd_pkg::*;

    t_result               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [FIFO_AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count, n_count;
    logic                  pop;
    logic [FIFO_AW-1:0]    wr_ptr_second;

    assign o_valid       = (r_count != '0);
    assign o_result      = r_mem[r_rd_ptr];
    // Two free slots are kept so a frame end with a final word never overflows.
    assign o_room        = (r_count <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign pop           = o_valid && i_ready;
    assign wr_ptr_second = r_wr_ptr + FIFO_AW'(1);

    always_comb begin
        n_wr_ptr = r_wr_ptr + FIFO_AW'(i_emit.count);
        n_rd_ptr = pop ? r_rd_ptr + FIFO_AW'(1) : r_rd_ptr;
        n_count  = r_count + FIFO_CNT_W'(i_emit.count) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_emit.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_emit.first;
        end
        if (i_emit.count == 2'd2) begin
            r_mem[wr_ptr_second] <= i_emit.second;
        end
    end

endmodule

// ===== rtl/core/modbus_tcp_response_deframer_core.sv =====
// Modbus TCP response deframer. Bytes of the response stream enter one per beat on
// the input channel, and frames are parsed back to back with no gap between them.
// Each result is registered in the result queue before output. The input takes one
// byte every cycle; the output delivers one result per beat from a four-entry result
// queue, and the input stalls only while that queue has fewer than two free entries.
// A frame end that also completes a register word writes two results into the queue
// at once (word first, then summary), so sustained input rate stays at one byte per
// cycle as long as the output is taken at least as fast as results are produced.
module modbus_tcp_response_deframer_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [7:0]                       i_data_byte,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic                             o_kind,
    output logic [15:0]                      o_transaction_id,
    output logic [7:0]                       o_unit_id,
    output logic [7:0]                       o_function_code,
    output logic [1:0]                       o_frame_status,
    output logic [7:0]                       o_exception_code,
    output logic [15:0]                      o_frame_length,
    output logic [15:0]                      o_register_value,
    output logic [mtrd_pkg::WORD_IDX_W-1:0]  o_word_index,
    output logic                             o_last
);
    import mtrd_pkg::*;

    t_emit   emit;
    t_result result;
    logic    room;

    assign o_ready = room;

    mtrd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (i_valid && room),
        .i_data_byte (i_data_byte),
        .o_emit      (emit)
    );

    mtrd_result_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_emit   (emit),
        .o_room   (room),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (result)
    );

    assign o_kind           = result.kind;
    assign o_transaction_id = result.trans_id;
    assign o_unit_id        = result.unit_id;
    assign o_function_code  = result.func_code;
    assign o_frame_status   = result.frame_status;
    assign o_exception_code = result.exc_code;
    assign o_frame_length   = result.frame_length;
    assign o_register_value = result.register_value;
    assign o_word_index     = result.word_index;
    assign o_last           = result.last;

endmodule

// ===== rtl/core/mtrd_checker.sv =====
module mtrd_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_ready,
    input logic [7:0]                      i_data_byte,
    input logic                            o_valid,
    input logic                            i_ready,
    input logic                            o_kind,
    input logic [15:0]                     o_transaction_id,
    input logic [7:0]                      o_unit_id,
    input logic [7:0]                      o_function_code,
    input logic [1:0]                      o_frame_status,
    input logic [7:0]                      o_exception_code,
    input logic [15:0]                     o_frame_length,
    input logic [15:0]                     o_register_value,
    input logic [mtrd_pkg::WORD_IDX_W-1:0] o_word_index,
    input logic                            o_last
);
    import mtrd_pkg::*;

    // Nothing is left in the result queue after reset.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result shown right after reset");

    // A stalled result beat keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_kind) && $stable(o_register_value)
            && $stable(o_word_index) && $stable(o_frame_status))
        else $error("stalled result changed");

    a_word_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_WORD) |->
            !o_last && (o_frame_status == ST_OK) && (o_exception_code == 8'h00))
        else $error("register word carries summary fields");

    a_summary_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_SUMMARY) |->
            o_last && (o_register_value == 16'h0000) && (o_word_index == '0))
        else $error("summary carries word fields");

    a_short_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_frame_status == ST_TOO_SHORT) |->
            (o_function_code == 8'h00) && (o_exception_code == 8'h00)
            && (o_frame_length < 16'd2))
        else $error("too short frame reported with function data");

endmodule

bind modbus_tcp_response_deframer_core mtrd_checker u_checker (.*);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import mtrd_pkg::*;

    localparam int DIR_ROWS    = 32;
    localparam int RAND_ITEMS  = 1850;
    localparam int TAIL_START  = DIR_ROWS + RAND_ITEMS - 300;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int BIG_FRAME   = 12;
    localparam int DRAIN_FRAME = 40;

    typedef struct packed {
        logic [7:0] data;
        logic       chk;
        t_status    st;
        logic [7:0] exc;
    } t_stim_row;

    // Hand-checked summaries are flagged on the last byte of each frame.
    localparam t_stim_row STIM_TABLE [DIR_ROWS] = '{
        // Length 0 ends the frame inside its own length field; the
        // protocol identifier is all ones and must be ignored.
        '{8'hFF, 1'b0, ST_OK, 8'h00}, '{8'hFF, 1'b0, ST_OK, 8'h00},
        '{8'hFF, 1'b0, ST_OK, 8'h00}, '{8'hFF, 1'b0, ST_OK, 8'h00},
        '{8'h00, 1'b0, ST_OK, 8'h00}, '{8'h00, 1'b1, ST_TOO_SHORT, 8'h00},
        // Length 1: only the unit identifier follows.
        '{8'h00, 1'b0, ST_OK, 8'h00}, '{8'h00, 1'b0, ST_OK, 8'h00},
        '{8'h00, 1'b0, ST_OK, 8'h00}, '{8'h00, 1'b0, ST_OK, 8'h00},
        '{8'h00, 1'b0, ST_OK, 8'h00}, '{8'h01, 1'b0, ST_OK, 8'h00},
        '{8'hFF, 1'b1, ST_TOO_SHORT, 8'h00},
        // Exception response that stops at its function code.
        '{8'h12, 1'b0, ST_OK, 8'h00}, '{8'h34, 1'b0, ST_OK, 8'h00},
        '{8'h00, 1'b0, ST_OK, 8'h00}, '{8'h00, 1'b0, ST_OK, 8'h00},
        '{8'h00, 1'b0, ST_OK, 8'h00}, '{8'h02, 1'b0, ST_OK, 8'h00},
        '{8'h01, 1'b0, ST_OK, 8'h00}, '{8'h83, 1'b1, ST_EXCEPTION, 8'h00},
        // Normal response carrying one register word.
        '{8'hAB, 1'b0, ST_OK, 8'h00}, '{8'hCD, 1'b0, ST_OK, 8'h00},
        '{8'h00, 1'b0, ST_OK, 8'h00}, '{8'h00, 1'b0, ST_OK, 8'h00},
        '{8'h00, 1'b0, ST_OK, 8'h00}, '{8'h05, 1'b0, ST_OK, 8'h00},
        '{8'h11, 1'b0, ST_OK, 8'h00}, '{8'h03, 1'b0, ST_OK, 8'h00},
        '{8'h02, 1'b0, ST_OK, 8'h00}, '{8'hFF, 1'b0, ST_OK, 8'h00},
        '{8'h00, 1'b1, ST_OK, 8'h00}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [7:0]            i_data_byte = 8'h00;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic                  o_kind;
    logic [15:0]           o_transaction_id;
    logic [7:0]            o_unit_id;
    logic [7:0]            o_function_code;
    logic [1:0]            o_frame_status;
    logic [7:0]            o_exception_code;
    logic [15:0]           o_frame_length;
    logic [15:0]           o_register_value;
    logic [WORD_IDX_W-1:0] o_word_index;
    logic                  o_last;

    modbus_tcp_response_deframer_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_data_byte      (i_data_byte),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_kind           (o_kind),
        .o_transaction_id (o_transaction_id),
        .o_unit_id        (o_unit_id),
        .o_function_code  (o_function_code),
        .o_frame_status   (o_frame_status),
        .o_exception_code (o_exception_code),
        .o_frame_length   (o_frame_length),
        .o_register_value (o_register_value),
        .o_word_index     (o_word_index),
        .o_last           (o_last)
    );

    always #1 i_clk = ~i_clk;

    int      cycle_count = 0;
    int      bytes_sent = 0;
    int      err_count = 0;
    int      rx_hold = 0;
    t_result pending_results [$];

    // Frame parser state of the predictor.
    int              mb_pos;
    logic [15:0]     mb_tid;
    logic [15:0]     mb_len;
    logic [7:0]      mb_unit;
    logic [7:0]      mb_func;
    logic [7:0]      mb_code;
    logic [7:0]      mb_count;
    logic [7:0]      mb_hi;
    logic [6:0]      mb_word;

    task automatic frame_clear();
        mb_pos   = 0;
        mb_tid   = '0;
        mb_len   = '0;
        mb_unit  = '0;
        mb_func  = '0;
        mb_code  = '0;
        mb_count = '0;
        mb_hi    = '0;
        mb_word  = '0;
    endtask

    function automatic t_result frame_result(logic k, t_status st, logic [7:0] ex,
                                             logic [15:0] val, logic [6:0] idx);
        t_result r;
        r.kind           = k;
        r.trans_id       = mb_tid;
        r.unit_id        = mb_unit;
        r.func_code      = mb_func;
        r.frame_status   = st;
        r.exc_code       = ex;
        r.frame_length   = mb_len;
        r.register_value = val;
        r.word_index     = idx;
        r.last           = k;
        return r;
    endfunction

    function automatic string describe(t_result r);
        return $sformatf({"kind=%0d tid=%04h unit=%02h fc=%02h st=%0d exc=%02h ",
                          "len=%04h val=%04h idx=%0d last=%0d"},
                         r.kind, r.trans_id, r.unit_id, r.func_code,
                         r.frame_status, r.exc_code, r.frame_length,
                         r.register_value, r.word_index, r.last);
    endfunction

    task automatic note_error(string msg);
        err_count++;
        if (err_count <= 10) begin
            $display("ERROR at cycle %0d: %s", cycle_count, msg);
        end
    endtask

    task automatic parse_byte(input logic [7:0] b);
        int         p;
        int         total;
        logic [7:0] ex;
        t_status    st;
        p = mb_pos;
        case (p)
            POS_TID_HI: mb_tid = {b, 8'h00};
            POS_TID_LO: mb_tid[7:0] = b;
            POS_LEN_HI: mb_len = {b, 8'h00};
            POS_LEN_LO: mb_len[7:0] = b;
            POS_UNIT:   mb_unit = b;
            POS_FUNC:   mb_func = b;
            POS_BYTE8: begin
                mb_code  = b;
                mb_count = b;
            end
            default: ;
        endcase
        total = int'(HDR_BYTES) + int'(mb_len);

        // Data bytes pair up from position 9; the word index keeps counting
        // past the byte count so that only words inside it are reported.
        if (p >= POS_DATA && !mb_func[FUNC_EXC_BIT]) begin
            if (p[0]) begin
                mb_hi = b;
            end else begin
                if ({mb_word, 1'b0} < mb_count) begin
                    pending_results.insert(pending_results.size(),
                        frame_result(KIND_WORD, ST_OK, 8'h00, {mb_hi, b}, mb_word));
                end
                mb_word = mb_word + 7'd1;
            end
        end

        if (p >= POS_LEN_LO && p + 1 >= total) begin
            ex = 8'h00;
            if (total < MIN_FRAME) begin
                st      = ST_TOO_SHORT;
                mb_func = 8'h00;
            end else if (mb_func[FUNC_EXC_BIT]) begin
                st = ST_EXCEPTION;
                if (total >= EXC_CODE_FRAME) begin
                    ex = mb_code;
                end
            end else begin
                st = ST_OK;
            end
            pending_results.insert(pending_results.size(),
                frame_result(KIND_SUMMARY, st, ex, 16'h0000, '0));
            frame_clear();
        end else begin
            mb_pos = p + 1;
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (bytes_sent < TAIL_START && cycle_count[10:9] != 2'b00
                && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 13);
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_data_byte <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        parse_byte(b);
        bytes_sent++;
    endtask

    task automatic hold_until_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // One complete frame: header plus exactly as many bytes as the length
    // field announces, so the parser stays in step with the stream.
    task automatic send_frame(input bit huge);
        logic [15:0] tid;
        logic [15:0] proto;
        logic [7:0]  fc;
        logic [7:0]  bc;
        int          len;
        int          nw;
        int          r;
        r     = $urandom_range(0, 99);
        nw    = $urandom_range(0, 16);
        tid   = 16'($urandom_range(0, 65535));
        proto = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535)) : 16'h0000;
        fc    = 8'($urandom_range(0, 127));
        bc    = 8'(2 * nw);
        len   = 3 + 2 * nw;
        if (huge) begin
            // Long enough for the word index to wrap around.
            bc  = 8'hFF;
            len = $urandom_range(400, 560);
        end else if (r < 6) begin
            len = $urandom_range(0, 1);
        end else if (r < 24) begin
            fc  = fc | 8'h80;
            len = $urandom_range(2, 7);
        end else begin
            if (r < 45) begin
                bc = 8'($urandom_range(0, 255));
            end
            if (r >= 92) begin
                fc = 8'($urandom_range(0, 255));
            end
            len = len - 2 + int'($urandom_range(0, 4));
            if (len < 2) begin
                len = 2;
            end
        end
        send_byte(tid[15:8]);
        send_byte(tid[7:0]);
        send_byte(proto[15:8]);
        send_byte(proto[7:0]);
        send_byte(8'(len >> 8));
        send_byte(8'(len));
        for (int i = 0; i < len; i++) begin
            case (i)
                1:       send_byte(fc);
                2:       send_byte(bc);
                default: send_byte(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (rx_hold > 0) begin
            i_ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else begin
            i_ready <= 1'b1;
            if (bytes_sent < TAIL_START && cycle_count[9:8] != 2'b11
                    && $urandom_range(0, 9) == 0) begin
                rx_hold <= $urandom_range(1, 13);
            end
        end
    end

    always @(posedge i_clk) begin
        t_result seen;
        t_result want;
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else if (i_rst_n && o_valid && i_ready) begin
            seen.kind           = o_kind;
            seen.trans_id       = o_transaction_id;
            seen.unit_id        = o_unit_id;
            seen.func_code      = o_function_code;
            seen.frame_status   = t_status'(o_frame_status);
            seen.exc_code       = o_exception_code;
            seen.frame_length   = o_frame_length;
            seen.register_value = o_register_value;
            seen.word_index     = o_word_index;
            seen.last           = o_last;
            if (pending_results.size() == 0) begin
                note_error({"result beat with nothing expected: ", describe(seen)});
            end else begin
                want = pending_results.pop_front();
                if (seen.kind !== want.kind
                        || seen.trans_id !== want.trans_id
                        || seen.unit_id !== want.unit_id
                        || seen.func_code !== want.func_code
                        || seen.frame_status !== want.frame_status
                        || seen.exc_code !== want.exc_code
                        || seen.frame_length !== want.frame_length
                        || seen.register_value !== want.register_value
                        || seen.word_index !== want.word_index
                        || seen.last !== want.last) begin
                    note_error({"expected ", describe(want), " got ", describe(seen)});
                end
            end
        end
    end

    initial begin
        t_result newest;
        int      frames;
        frame_clear();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            send_byte(STIM_TABLE[i].data);
            if (STIM_TABLE[i].chk) begin
                newest = pending_results[$];
                if (newest.kind !== KIND_SUMMARY
                        || newest.frame_status !== STIM_TABLE[i].st
                        || newest.exc_code !== STIM_TABLE[i].exc) begin
                    note_error($sformatf("row %0d: summary should be st=%0d exc=%02h, got %s",
                                         i, STIM_TABLE[i].st, STIM_TABLE[i].exc,
                                         describe(newest)));
                end
            end
        end
        hold_until_drained();

        frames = 0;
        while (bytes_sent < DIR_ROWS + RAND_ITEMS) begin
            send_frame(frames == BIG_FRAME);
            frames++;
            if (frames == DRAIN_FRAME) begin
                hold_until_drained();
            end
        end
        hold_until_drained();
        repeat (20) @(posedge i_clk);

        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/mtrd_pkg.sv
rtl/core/mtrd_parser.sv
rtl/core/mtrd_result_fifo.sv
rtl/core/modbus_tcp_response_deframer_core.sv
rtl/core/mtrd_checker.sv
tb/sv/tb.sv
